[rtl/core/asl_pkg.sv]
// ----------------------------------------------------------------------------
// asl_pkg
// shared types, register indexes, widths and reset values of the audio
// safety limiter
// ----------------------------------------------------------------------------
package asl_pkg;

  // default datapath geometry
  localparam int unsigned SampleWidthDef  = 24;
  localparam int unsigned FractionBitsDef = 20;
  localparam int unsigned GuardBitsDef    = 16;

  // configuration port
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 32;

  // register widths
  localparam int unsigned ShiftW      = 5;
  localparam int unsigned ClipTripW   = 32;
  localparam int unsigned DcTripW     = 23;
  localparam int unsigned PeakTripW   = 25;
  localparam int unsigned HoldTripW   = 17;
  localparam int unsigned MuteLenW    = 16;

  // counters
  localparam int unsigned ClipCountW  = 32;
  localparam int unsigned HighCountW  = 18;

  // register reset values
  localparam logic [ShiftW-1:0]    DcShiftRst    = ShiftW'(13);
  localparam logic [ShiftW-1:0]    PeakShiftRst  = ShiftW'(17);
  localparam logic [ClipTripW-1:0] ClipTripRst   = ClipTripW'(1000);
  localparam logic [DcTripW-1:0]   DcTripRst     = DcTripW'(524288);
  localparam logic [PeakTripW-1:0] PeakTripRst   = PeakTripW'(1038090);
  localparam logic [HoldTripW-1:0] HoldTripRst   = HoldTripW'(48000);
  localparam logic [MuteLenW-1:0]  MuteLengthRst = MuteLenW'(24000);

  // register map
  typedef enum logic [CfgIndexW-1:0] {
    CfgDcShift    = 3'd0,
    CfgPeakShift  = 3'd1,
    CfgClipTrip   = 3'd2,
    CfgDcTrip     = 3'd3,
    CfgPeakTrip   = 3'd4,
    CfgHoldTrip   = 3'd5,
    CfgMuteLength = 3'd6
  } cfg_reg_e;

  // item kinds carried in tuser bit 0
  typedef enum logic {
    KindSample = 1'b0,
    KindCheck  = 1'b1
  } kind_e;

endpackage

[rtl/core/audio_safety_limiter.sv]
// ----------------------------------------------------------------------------
// audio_safety_limiter
// dc blocker, peak meter and hard clipper with a timed emergency mute
// ----------------------------------------------------------------------------
// One item per clock, sustained while the result stream takes results. An
// accepted item sits in an input register, then all of its work (dc
// integrator update, dc removal, peak tracking, clipping, mute countdown, or
// the safety check) is done combinationally and lands in the result register
// together with the state update. The dc and peak recurrences close
// combinationally on the state registers, which is what allows a new item
// every clock. A result waiting in the output register holds the item behind
// it in the input register, so input ready drops until that result transfers.
// Samples are signed Q20 (Q of FRACTION_BITS); internal trackers carry
// GUARD_BITS extra fraction bits.
// Configuration writes are always accepted and take effect for the next item;
// write them only while the block is idle. Indexes beyond the register map
// are ignored.
module audio_safety_limiter #(
  parameter int unsigned SAMPLE_WIDTH  = asl_pkg::SampleWidthDef,
  parameter int unsigned FRACTION_BITS = asl_pkg::FractionBitsDef,
  parameter int unsigned GUARD_BITS    = asl_pkg::GuardBitsDef,
  // derived, do not override
  parameter int unsigned InDataW  = ((SAMPLE_WIDTH + 7) / 8) * 8,
  parameter int unsigned OutDataW = (((FRACTION_BITS + 2) + asl_pkg::ClipCountW
                                      + 2 * SAMPLE_WIDTH + 2 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [asl_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [asl_pkg::CfgDataW-1:0]  cfg_data_i,

  // input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [InDataW-1:0]            s_axis_tdata_i,  // in_sample, zero pad
  input  logic [1:0]                    s_axis_tuser_i,  // kind, invalid

  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // out_sample, clip_count, peak_level, dc_level, muted, zero pad
  output logic [OutDataW-1:0]           m_axis_tdata_o
);

  // widths
  localparam int unsigned OutW  = FRACTION_BITS + 2;            // out_sample
  localparam int unsigned DcW   = SAMPLE_WIDTH + GUARD_BITS;    // dc estimate
  localparam int unsigned PkW   = SAMPLE_WIDTH + 1 + GUARD_BITS; // peak tracker
  localparam int unsigned YW    = (SAMPLE_WIDTH + 1 > FRACTION_BITS + 2) ?
                                  SAMPLE_WIDTH + 1 : FRACTION_BITS + 2;
  localparam int unsigned PackW = OutW + asl_pkg::ClipCountW + 2 * SAMPLE_WIDTH + 2;
  localparam int unsigned DcCmpW = DcW + asl_pkg::DcTripW + GUARD_BITS;
  localparam int unsigned PkCmpW = PkW + asl_pkg::PeakTripW + GUARD_BITS;

  localparam logic signed [YW-1:0] OneY    = YW'(1) << FRACTION_BITS;
  localparam logic signed [YW-1:0] MinusOneY = -OneY;
  localparam logic [asl_pkg::ClipCountW-1:0] ClipMax = '1;
  localparam logic [asl_pkg::HighCountW-1:0] HighMax = '1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [asl_pkg::ShiftW-1:0]    dc_shift_q, peak_shift_q;
  logic [asl_pkg::ClipTripW-1:0] clip_trip_q;
  logic [asl_pkg::DcTripW-1:0]   dc_trip_q;
  logic [asl_pkg::PeakTripW-1:0] peak_trip_q;
  logic [asl_pkg::HoldTripW-1:0] hold_trip_q;
  logic [asl_pkg::MuteLenW-1:0]  mute_length_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_shift_q    <= asl_pkg::DcShiftRst;
      peak_shift_q  <= asl_pkg::PeakShiftRst;
      clip_trip_q   <= asl_pkg::ClipTripRst;
      dc_trip_q     <= asl_pkg::DcTripRst;
      peak_trip_q   <= asl_pkg::PeakTripRst;
      hold_trip_q   <= asl_pkg::HoldTripRst;
      mute_length_q <= asl_pkg::MuteLengthRst;
    end else if (cfg_valid_i) begin
      case (asl_pkg::cfg_reg_e'(cfg_index_i))
        asl_pkg::CfgDcShift:    dc_shift_q    <= cfg_data_i[asl_pkg::ShiftW-1:0];
        asl_pkg::CfgPeakShift:  peak_shift_q  <= cfg_data_i[asl_pkg::ShiftW-1:0];
        asl_pkg::CfgClipTrip:   clip_trip_q   <= cfg_data_i[asl_pkg::ClipTripW-1:0];
        asl_pkg::CfgDcTrip:     dc_trip_q     <= cfg_data_i[asl_pkg::DcTripW-1:0];
        asl_pkg::CfgPeakTrip:   peak_trip_q   <= cfg_data_i[asl_pkg::PeakTripW-1:0];
        asl_pkg::CfgHoldTrip:   hold_trip_q   <= cfg_data_i[asl_pkg::HoldTripW-1:0];
        asl_pkg::CfgMuteLength: mute_length_q <= cfg_data_i[asl_pkg::MuteLenW-1:0];
        default: ; // unmapped index, ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake: input register feeds the result register in one step
  // --------------------------------------------------------------------------
  logic                           in_valid_q;
  logic                           in_kind_q;
  logic                           in_invalid_q;
  logic signed [SAMPLE_WIDTH-1:0] in_sample_q;
  logic                           out_valid_q;
  logic [PackW-1:0]               out_data_q;
  logic                           advance;
  logic                           in_take;

  // item moves on when the result register is free or being drained
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_take || (in_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && !m_axis_tready_i);
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q    <= s_axis_tuser_i[0];
      in_invalid_q <= s_axis_tuser_i[1];
      in_sample_q  <= s_axis_tdata_i[SAMPLE_WIDTH-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // tracker state
  // --------------------------------------------------------------------------
  logic signed [DcW-1:0]           dc_q, dc_d;
  logic [PkW-1:0]                  peak_q, peak_d;
  logic [asl_pkg::ClipCountW-1:0]  clip_q, clip_d;
  logic                            mute_q, mute_d;
  logic [asl_pkg::MuteLenW-1:0]    remain_q, remain_d;
  logic [asl_pkg::HighCountW-1:0]  high_q, high_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q     <= '0;
      peak_q   <= '0;
      clip_q   <= '0;
      mute_q   <= 1'b0;
      remain_q <= '0;
      high_q   <= '0;
    end else if (advance) begin
      dc_q     <= dc_d;
      peak_q   <= peak_d;
      clip_q   <= clip_d;
      mute_q   <= mute_d;
      remain_q <= remain_d;
      high_q   <= high_d;
    end
  end

  // --------------------------------------------------------------------------
  // sample path
  // --------------------------------------------------------------------------
  logic signed [DcW:0]            x_ext, dc_diff, dc_step, dc_sum;
  logic signed [DcW-1:0]          dc_new;
  logic signed [SAMPLE_WIDTH-1:0] dc_int;
  logic signed [YW-1:0]           y;
  logic [YW-1:0]                  y_abs;
  logic [PkW-1:0]                 mag, peak_dec, peak_new;
  logic                           clip_pos, clip_neg;
  logic signed [OutW-1:0]         y_clip;
  logic [asl_pkg::ClipCountW-1:0] clip_inc;

  // integrator: dc += floor(((x << guard) - dc) / 2^dc_shift)
  assign x_ext   = (DcW + 1)'($signed({in_sample_q, {GUARD_BITS{1'b0}}}));
  assign dc_diff = x_ext - (DcW + 1)'(dc_q);
  assign dc_step = dc_diff >>> dc_shift_q;
  assign dc_sum  = (DcW + 1)'(dc_q) + dc_step;
  assign dc_new  = dc_sum[DcW-1:0];
  assign dc_int  = dc_new[DcW-1:GUARD_BITS];

  // cleaned sample and its magnitude
  assign y     = YW'(in_sample_q) - YW'(dc_int);
  assign y_abs = y[YW-1] ? YW'(-y) : YW'(y);
  assign mag   = {y_abs[SAMPLE_WIDTH:0], {GUARD_BITS{1'b0}}};

  // peak: attack instantly, decay by a shift otherwise
  assign peak_dec = peak_q - (peak_q >> peak_shift_q);
  assign peak_new = (mag > peak_q) ? mag : peak_dec;

  // hard clip to plus or minus one
  assign clip_pos = y > OneY;
  assign clip_neg = y < MinusOneY;
  always_comb begin
    if (clip_pos) begin
      y_clip = OutW'(OneY);
    end else if (clip_neg) begin
      y_clip = OutW'(MinusOneY);
    end else begin
      y_clip = y[OutW-1:0];
    end
  end

  assign clip_inc = (clip_q == ClipMax) ? clip_q : clip_q + 1'b1;

  // --------------------------------------------------------------------------
  // safety check
  // --------------------------------------------------------------------------
  logic [DcW-1:0]                 dc_mag;
  logic                           clip_hit, dc_hit, peak_high, hold_hit;
  logic [asl_pkg::HighCountW-1:0] high_inc;

  assign dc_mag    = dc_q[DcW-1] ? DcW'(-dc_q) : DcW'(dc_q);
  assign clip_hit  = clip_q > clip_trip_q;
  assign dc_hit    = DcCmpW'(dc_mag) > DcCmpW'({dc_trip_q, {GUARD_BITS{1'b0}}});
  assign peak_high = PkCmpW'(peak_q) > PkCmpW'({peak_trip_q, {GUARD_BITS{1'b0}}});
  assign high_inc  = (high_q == HighMax) ? high_q : high_q + 1'b1;
  assign hold_hit  = peak_high
                     && (asl_pkg::HighCountW'(hold_trip_q) < high_inc);

  // --------------------------------------------------------------------------
  // next state and result
  // --------------------------------------------------------------------------
  logic signed [OutW-1:0] out_sample;

  always_comb begin
    dc_d       = dc_q;
    peak_d     = peak_q;
    clip_d     = clip_q;
    mute_d     = mute_q;
    remain_d   = remain_q;
    high_d     = high_q;
    out_sample = '0;

    case (asl_pkg::kind_e'(in_kind_q))
      asl_pkg::KindCheck: begin
        if (clip_hit) begin
          clip_d = '0;
        end
        if (dc_hit) begin
          dc_d = '0;
        end
        if (peak_high) begin
          high_d = hold_hit ? '0 : high_inc;
        end
        if (clip_hit || dc_hit || hold_hit) begin
          mute_d   = 1'b1;
          remain_d = mute_length_q;
        end
      end
      asl_pkg::KindSample: begin
        if (in_invalid_q) begin
          // nan or inf source: counted as a clip, trackers untouched
          clip_d = clip_inc;
        end else begin
          dc_d   = dc_new;
          peak_d = peak_new;
          if (clip_pos || clip_neg) begin
            clip_d = clip_inc;
          end
          if (mute_q) begin
            if (remain_q != '0) begin
              remain_d = remain_q - 1'b1;
            end else begin
              mute_d = 1'b0;
            end
          end else begin
            out_sample = y_clip;
          end
        end
      end
      default: ;
    endcase
  end

  // result register, fields packed from the lowest bit up
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {mute_d,
                     dc_d[DcW-1:GUARD_BITS],
                     peak_d[PkW-1:GUARD_BITS],
                     clip_d,
                     out_sample};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'(out_data_q);

endmodule

[bench/audio_safety_limiter_test.sv]
// ----------------------------------------------------------------------------
// audio_safety_limiter_test
// self-checking bench for the audio safety limiter: a directed opening covers
// the sample extremes, clipping at +-1.0, invalid samples, the safety check
// with every trip and the mute countdown. Random phases follow under several
// register settings, the extremes among them. A scoreboard class predicts each
// result from the accepted input and checks the result stream field by field.
// ----------------------------------------------------------------------------
module audio_safety_limiter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned InW   = 24;
  localparam int          Guard = asl_pkg::GuardBitsDef;
  localparam longint      QOne  = longint'(1) << asl_pkg::FractionBitsDef;
  localparam longint      SMax  = 8388607;
  localparam longint      SMin  = -8388608;

  // index past the register map, must be ignored
  localparam logic [asl_pkg::CfgIndexW-1:0] CfgUnmapped = 3'd7;

  // one result, laid out as on m_axis_tdata_o (out_sample in the lowest bits)
  typedef struct packed {
    logic               muted;
    logic signed [23:0] dc_level;
    logic [24:0]        peak_level;
    logic [31:0]        clip_count;
    logic signed [21:0] out_sample;
  } limiter_out_t;

  localparam int unsigned OutW = $bits(limiter_out_t);

  // register setting styles for the random phases
  typedef enum int {
    SetDefault,
    SetAllMax,
    SetAllZero,
    SetModerate,
    SetRawRandom
  } setting_e;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the guard state and registers
  // --------------------------------------------------------------------------
  class limiter_scoreboard;
    logic [asl_pkg::ShiftW-1:0]     dc_shift;
    logic [asl_pkg::ShiftW-1:0]     peak_shift;
    logic [asl_pkg::ClipTripW-1:0]  clip_trip;
    logic [asl_pkg::DcTripW-1:0]    dc_trip;
    logic [asl_pkg::PeakTripW-1:0]  peak_trip;
    logic [asl_pkg::HoldTripW-1:0]  hold_trip;
    logic [asl_pkg::MuteLenW-1:0]   mute_length;
    longint                         dc_acc;
    longint                         peak_acc;
    logic [asl_pkg::ClipCountW-1:0] clip_cnt;
    logic                           mute_on;
    logic [asl_pkg::MuteLenW-1:0]   mute_left;
    logic [asl_pkg::HighCountW-1:0] high_cnt;
    limiter_out_t                   expected_q[$];
    int                             errors;

    function new();
      dc_shift    = asl_pkg::DcShiftRst;
      peak_shift  = asl_pkg::PeakShiftRst;
      clip_trip   = asl_pkg::ClipTripRst;
      dc_trip     = asl_pkg::DcTripRst;
      peak_trip   = asl_pkg::PeakTripRst;
      hold_trip   = asl_pkg::HoldTripRst;
      mute_length = asl_pkg::MuteLengthRst;
      dc_acc      = 0;
      peak_acc    = 0;
      clip_cnt    = '0;
      mute_on     = 1'b0;
      mute_left   = '0;
      high_cnt    = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [asl_pkg::CfgIndexW-1:0] idx,
                            logic [asl_pkg::CfgDataW-1:0] data);
      case (idx)
        asl_pkg::CfgDcShift:    dc_shift    = data[asl_pkg::ShiftW-1:0];
        asl_pkg::CfgPeakShift:  peak_shift  = data[asl_pkg::ShiftW-1:0];
        asl_pkg::CfgClipTrip:   clip_trip   = data[asl_pkg::ClipTripW-1:0];
        asl_pkg::CfgDcTrip:     dc_trip     = data[asl_pkg::DcTripW-1:0];
        asl_pkg::CfgPeakTrip:   peak_trip   = data[asl_pkg::PeakTripW-1:0];
        asl_pkg::CfgHoldTrip:   hold_trip   = data[asl_pkg::HoldTripW-1:0];
        asl_pkg::CfgMuteLength: mute_length = data[asl_pkg::MuteLenW-1:0];
        default: ;
      endcase
    endfunction

    function void arm_mute();
      mute_on   = 1'b1;
      mute_left = mute_length;
    endfunction

    function void count_clip();
      if (clip_cnt != '1) clip_cnt++;
    endfunction

    // works out the result of one accepted item and queues it
    function void note_input(asl_pkg::kind_e kind, logic [InW-1:0] raw, logic bad);
      limiter_out_t r;
      longint       x;
      longint       y;
      longint       mag;
      r = '0;
      y = 0;
      if (kind == asl_pkg::KindCheck) begin
        // clip check, then dc check, then sustained peak check
        if (clip_cnt > clip_trip) begin
          arm_mute();
          clip_cnt = '0;
        end
        mag = (dc_acc < 0) ? -dc_acc : dc_acc;
        if (mag > (longint'(dc_trip) <<< Guard)) begin
          arm_mute();
          dc_acc = 0;
        end
        if (peak_acc > (longint'(peak_trip) <<< Guard)) begin
          if (high_cnt != '1) high_cnt++;
          if (high_cnt > hold_trip) begin
            arm_mute();
            high_cnt = '0;
          end
        end
      end else if (bad) begin
        count_clip();
      end else begin
        x      = longint'($signed(raw));
        dc_acc = dc_acc + (((x <<< Guard) - dc_acc) >>> dc_shift);
        y      = x - (dc_acc >>> Guard);
        mag    = ((y < 0) ? -y : y) <<< Guard;
        if (mag > peak_acc) peak_acc = mag;
        else peak_acc = peak_acc - (peak_acc >>> peak_shift);
        if (y > QOne) begin
          y = QOne;
          count_clip();
        end else if (y < -QOne) begin
          y = -QOne;
          count_clip();
        end
        // muted samples still feed dc, peak and clip counting
        if (mute_on) begin
          if (mute_left != '0) mute_left--;
          else mute_on = 1'b0;
          y = 0;
        end
      end
      r.out_sample = 22'(y);
      r.clip_count = clip_cnt;
      r.peak_level = 25'(peak_acc >>> Guard);
      r.dc_level   = 24'(dc_acc >>> Guard);
      r.muted      = mute_on;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("%0t ns mismatch: %s", $realtime, msg);
    endtask

    task check_result(limiter_out_t got);
      limiter_out_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result transfer with no item outstanding");
        return;
      end
      want = expected_q.pop_front();
      if (got.out_sample !== want.out_sample)
        report_mismatch($sformatf("out_sample %0d, expected %0d",
                                  got.out_sample, want.out_sample));
      if (got.clip_count !== want.clip_count)
        report_mismatch($sformatf("clip_count %0d, expected %0d",
                                  got.clip_count, want.clip_count));
      if (got.peak_level !== want.peak_level)
        report_mismatch($sformatf("peak_level %0d, expected %0d",
                                  got.peak_level, want.peak_level));
      if (got.dc_level !== want.dc_level)
        report_mismatch($sformatf("dc_level %0d, expected %0d",
                                  got.dc_level, want.dc_level));
      if (got.muted !== want.muted)
        report_mismatch($sformatf("muted %0b, expected %0b", got.muted, want.muted));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block
  // --------------------------------------------------------------------------
  logic                          clk_i;
  logic                          rst_ni          = 1'b0;
  logic                          cfg_valid_i     = 1'b0;
  logic                          cfg_ready_o;
  logic [asl_pkg::CfgIndexW-1:0] cfg_index_i     = '0;
  logic [asl_pkg::CfgDataW-1:0]  cfg_data_i      = '0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [InW-1:0]                s_axis_tdata_i  = '0;  // in_sample
  logic [1:0]                    s_axis_tuser_i  = '0;  // kind, invalid
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  // out_sample, clip_count, peak_level, dc_level, muted
  logic [OutW-1:0]               m_axis_tdata_o;

  // no random idling on either side while set
  logic                          steady = 1'b0;

  limiter_scoreboard sb = new();

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  audio_safety_limiter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // result side: random back-pressure, ready low about 17 times in a hundred
  always @(posedge clk_i) begin
    if (steady) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= ($urandom_range(99) >= 17);
  end

  // every result transfer is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(limiter_out_t'(m_axis_tdata_o));
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // one item transfer, with a one-cycle gap in front of it now and then
  task automatic send_item(asl_pkg::kind_e kind, logic [InW-1:0] raw, logic bad);
    if (!steady && $urandom_range(99) < 20) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= raw;
    s_axis_tuser_i  <= {bad, kind};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(kind, raw, bad);
  endtask

  // stop sending and wait until every expected result has arrived
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    // input and result register pipeline, leave it a little more
    repeat (4) @(posedge clk_i);
  endtask

  // one register transfer; valid stays up for back-to-back writes
  task automatic write_reg(logic [asl_pkg::CfgIndexW-1:0] idx,
                           logic [asl_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic load_config(logic [asl_pkg::CfgDataW-1:0] dc_sh,
                             logic [asl_pkg::CfgDataW-1:0] pk_sh,
                             logic [asl_pkg::CfgDataW-1:0] clip_t,
                             logic [asl_pkg::CfgDataW-1:0] dc_t,
                             logic [asl_pkg::CfgDataW-1:0] peak_t,
                             logic [asl_pkg::CfgDataW-1:0] hold_t,
                             logic [asl_pkg::CfgDataW-1:0] mute_len);
    write_reg(asl_pkg::CfgDcShift, dc_sh);
    write_reg(asl_pkg::CfgPeakShift, pk_sh);
    write_reg(asl_pkg::CfgClipTrip, clip_t);
    write_reg(asl_pkg::CfgDcTrip, dc_t);
    write_reg(asl_pkg::CfgPeakTrip, peak_t);
    write_reg(asl_pkg::CfgHoldTrip, hold_t);
    write_reg(asl_pkg::CfgMuteLength, mute_len);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic pick_config(setting_e style);
    case (style)
      SetDefault:
        load_config(asl_pkg::DcShiftRst, asl_pkg::PeakShiftRst, asl_pkg::ClipTripRst,
                    asl_pkg::DcTripRst, asl_pkg::PeakTripRst, asl_pkg::HoldTripRst,
                    asl_pkg::MuteLengthRst);
      SetAllMax:
        load_config('1, '1, '1, '1, '1, '1, '1);
      SetAllZero:
        load_config('0, '0, '0, '0, '0, '0, '0);
      SetModerate:
        // small trips so the check fires often, short mutes
        load_config($urandom_range(20, 4), $urandom_range(24, 4), $urandom_range(40),
                    $urandom_range(1 << 20), $urandom_range(1 << 21),
                    $urandom_range(20), $urandom_range(40));
      default:
        load_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom);
    endcase
  endtask

  // random items around a per-phase dc offset, with checks, invalid samples,
  // near-clip values and full-range values mixed in
  task automatic stream_random(int count);
    longint offset;
    int     shamt;
    int     roll;
    longint v;
    offset = longint'($urandom_range(1 << 22)) - (1 << 21);
    shamt  = $urandom_range(31, 9);
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        send_item(asl_pkg::KindCheck, InW'($urandom), 1'($urandom));
      end else if (roll < 15) begin
        send_item(asl_pkg::KindSample, InW'($urandom), 1'b1);
      end else if (roll < 22) begin
        send_item(asl_pkg::KindSample, InW'($urandom), 1'b0);
      end else if (roll < 30) begin
        v = QOne + longint'($urandom_range(16)) - 8;
        if ($urandom_range(1) != 0) v = -v;
        send_item(asl_pkg::KindSample, InW'(v), 1'b0);
      end else begin
        v = offset + (longint'($signed($urandom)) >>> shamt);
        if (v > SMax) v = SMax;
        if (v < SMin) v = SMin;
        send_item(asl_pkg::KindSample, InW'(v), 1'b0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  setting_e plan[8] = '{SetModerate, SetDefault, SetAllMax, SetModerate,
                        SetAllZero, SetRawRandom, SetModerate, SetModerate};

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: extremes, clip edges, invalid samples, checks
    send_item(asl_pkg::KindSample, InW'(0), 1'b0);
    send_item(asl_pkg::KindSample, InW'(SMax), 1'b0);
    send_item(asl_pkg::KindSample, InW'(SMin), 1'b0);
    send_item(asl_pkg::KindSample, InW'(QOne), 1'b0);
    send_item(asl_pkg::KindSample, InW'(-QOne), 1'b0);
    send_item(asl_pkg::KindSample, InW'(QOne + 1), 1'b0);
    send_item(asl_pkg::KindSample, InW'(-QOne - 1), 1'b0);
    send_item(asl_pkg::KindSample, '1, 1'b1);
    send_item(asl_pkg::KindSample, '0, 1'b1);
    // the invalid flag means nothing on a check
    send_item(asl_pkg::KindCheck, InW'(24'h5a5a5a), 1'b1);
    send_item(asl_pkg::KindCheck, '0, 1'b0);
    drain();

    // all trips at zero, dc almost frozen, instant peak decay
    write_reg(CfgUnmapped, '1);
    load_config(31, 0, 0, 0, 0, 0, 3);
    send_item(asl_pkg::KindSample, InW'(-5000), 1'b0);
    send_item(asl_pkg::KindSample, InW'(SMax), 1'b0);
    send_item(asl_pkg::KindSample, InW'(12345), 1'b1);
    // clip, dc and high-level checks all trip here
    send_item(asl_pkg::KindCheck, '0, 1'b0);
    // mute counts down, then the output comes back
    repeat (5) send_item(asl_pkg::KindSample, InW'(QOne / 2), 1'b0);
    send_item(asl_pkg::KindSample, InW'(SMin), 1'b0);
    send_item(asl_pkg::KindCheck, '0, 1'b0);
    drain();

    // random phases, each one ends with the stream drained
    foreach (plan[p]) begin
      pick_config(plan[p]);
      if (p == 3) steady <= 1'b1;
      stream_random(240);
      drain();
      steady <= 1'b0;
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[audio_safety_limiter.f]
rtl/core/asl_pkg.sv
rtl/core/audio_safety_limiter.sv
bench/audio_safety_limiter_test.sv
